// ===== hw/rtl/wbs_pkg.sv =====
// Package for the wildcard byte signature scanner: item structs, configuration
// struct, register index codes and fixed field widths.
// No dependencies.
`default_nettype none

package wbs_pkg;

    localparam int PATTERN_MAX_DEF  = 16;
    localparam int WINDOW_DEPTH_DEF = 32;

    localparam int PATTERN_BYTES = 16;
    localparam int PAT_IDX_W     = $clog2(PATTERN_BYTES);
    localparam int LEN_W         = 5;
    localparam int DISP_OFF_W    = 5;
    localparam int DISP_BYTES    = 4;
    localparam int DISP_SKIP_W   = 6;
    // largest displacement_offset + 4
    localparam int OFF_SUM_MAX   = (2 ** DISP_OFF_W) - 1 + DISP_BYTES;
    localparam int POS_W         = 32;
    localparam int SKIP_W        = 32;
    localparam int ADDR_W        = 64;
    localparam int DISP_W        = 32;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELATIVE_MODE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_OFFSET   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] result_address;
    } out_item_t;

    typedef struct packed {
        logic [63:0]           pattern_low_bytes;
        logic [63:0]           pattern_high_bytes;
        logic [15:0]           care_mask;
        logic [LEN_W-1:0]      pattern_length;
        logic [SKIP_W-1:0]     matches_to_skip;
        logic                  relative_mode;
        logic [DISP_OFF_W-1:0] displacement_offset;
        logic [ADDR_W-1:0]     base_address;
    } cfg_t;

    // window compare outcome for the start that just became complete
    typedef struct packed {
        logic              hit;
        logic [POS_W-1:0]  start;
        logic [DISP_W-1:0] disp;
    } match_t;

    // scan stage to resolve stage
    typedef struct packed {
        logic                   found;
        logic [POS_W-1:0]       hit_offset;
        logic [DISP_W-1:0]      disp;
        logic                   rel;
        logic [DISP_SKIP_W-1:0] disp_skip;
    } hit_rec_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wildcard_byte_signature_scanner_top.sv =====
// Top level of the wildcard byte signature scanner: configuration registers,
// scan stage and resolve stage. Depends on wbs_pkg, wbs_scan, wbs_resolve.
//
// Usage:
//   Region bytes enter on byte_valid/byte_ready/byte_item, one item per byte,
//   last_byte set on the final byte of a region. At most one result item per
//   region leaves on result_valid/result_ready/result_item: found with the hit
//   address (or resolved relative target), or not-found on the last byte.
//   Bytes after a reported hit are swallowed until the last byte restarts.
//   Configuration: cfg_write with cfg_index/cfg_data writes one register per
//   cycle; write only while no item is in flight.
//   Throughput: one byte per cycle while byte_ready is high; the window
//   compare for all pattern positions is done in parallel in the cycle
//   the byte is accepted. A result is registered first in the scan stage's
//   hit record register, then the 64-bit address add goes into the output
//   register before result_valid rises.
//   Stall: a held result keeps byte_ready high until the hit record stage is
//   also full; then byte_ready drops until result_ready returns.
//   Reset: rst_n low resets config, window and control registers (pattern
//   length 1, all else zero) and empties both stages; no clearing pass.
`default_nettype none

module wildcard_byte_signature_scanner_top #(
    parameter int PATTERN_MAX  = wbs_pkg::PATTERN_MAX_DEF,
    parameter int WINDOW_DEPTH = wbs_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [wbs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           byte_valid,
    output logic                                byte_ready,
    input  wire wbs_pkg::in_item_t              byte_item,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output wbs_pkg::out_item_t                  result_item
);

    localparam wbs_pkg::cfg_t CFG_RESET = '{
        pattern_low_bytes:   '0,
        pattern_high_bytes:  '0,
        care_mask:           '0,
        pattern_length:      wbs_pkg::LEN_W'(1),
        matches_to_skip:     '0,
        relative_mode:       1'b0,
        displacement_offset: '0,
        base_address:        '0
    };

    wbs_pkg::cfg_t     cfg_reg;
    wbs_pkg::cfg_t     cfg_next;
    wbs_pkg::hit_rec_t rec;
    logic              rec_valid;
    logic              rec_ready;
    logic              take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                wbs_pkg::REG_PATTERN_LOW:   cfg_next.pattern_low_bytes   = cfg_data;
                wbs_pkg::REG_PATTERN_HIGH:  cfg_next.pattern_high_bytes  = cfg_data;
                wbs_pkg::REG_CARE_MASK:     cfg_next.care_mask           = cfg_data[15:0];
                wbs_pkg::REG_PATTERN_LEN:
                    cfg_next.pattern_length = cfg_data[wbs_pkg::LEN_W-1:0];
                wbs_pkg::REG_SKIP_COUNT:
                    cfg_next.matches_to_skip = cfg_data[wbs_pkg::SKIP_W-1:0];
                wbs_pkg::REG_RELATIVE_MODE: cfg_next.relative_mode       = cfg_data[0];
                wbs_pkg::REG_DISP_OFFSET:
                    cfg_next.displacement_offset = cfg_data[wbs_pkg::DISP_OFF_W-1:0];
                wbs_pkg::REG_BASE_ADDRESS:  cfg_next.base_address        = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign take = byte_valid && byte_ready;

    wbs_scan #(
        .PATTERN_MAX  (PATTERN_MAX),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .take      (take),
        .item      (byte_item),
        .ready     (byte_ready),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    wbs_resolve u_resolve (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (cfg_reg.base_address),
        .rec_valid    (rec_valid),
        .rec_ready    (rec_ready),
        .rec          (rec),
        .out_valid    (result_valid),
        .out_ready    (result_ready),
        .out_item     (result_item)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/wbs_match.sv =====
// Window compare: checks the byte window against the wildcard pattern and
// picks out the 32-bit displacement. Pure combinational. Depends on wbs_pkg.
`default_nettype none

module wbs_match #(
    parameter int PATTERN_MAX  = wbs_pkg::PATTERN_MAX_DEF,
    parameter int WINDOW_DEPTH = wbs_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic [7:0]               window [WINDOW_DEPTH],
    input  wire logic [wbs_pkg::POS_W-1:0] pos,
    input  wire wbs_pkg::cfg_t            cfg,
    output wbs_pkg::match_t               match
);

    localparam int SPAN   = (WINDOW_DEPTH > wbs_pkg::OFF_SUM_MAX) ?
                            WINDOW_DEPTH : wbs_pkg::OFF_SUM_MAX;
    localparam int NEED_W = $clog2(SPAN + 1);
    localparam int WI_W   = $clog2(WINDOW_DEPTH);

    logic [NEED_W-1:0] len_raw;
    logic [NEED_W-1:0] len;
    logic [NEED_W-1:0] off4;
    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] first_k;
    logic [NEED_W-1:0] top0;
    logic [NEED_W-1:0] top1;
    logic [NEED_W-1:0] top2;
    logic [NEED_W-1:0] top3;
    logic              in_range;
    logic [wbs_pkg::PATTERN_BYTES*8-1:0] pat;
    logic [WINDOW_DEPTH-1:0] ok;

    assign pat     = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};
    assign len_raw = NEED_W'(cfg.pattern_length);

    always_comb
    begin
        if (len_raw == '0)
        begin
            len = NEED_W'(1);
        end
        else if (len_raw > NEED_W'(PATTERN_MAX))
        begin
            len = NEED_W'(PATTERN_MAX);
        end
        else
        begin
            len = len_raw;
        end
    end

    assign off4 = NEED_W'(cfg.displacement_offset) + NEED_W'(wbs_pkg::DISP_BYTES);
    assign need = (cfg.relative_mode && (off4 > len)) ? off4 : len;
    assign first_k = need - len;

    assign in_range = (need <= NEED_W'(WINDOW_DEPTH)) &&
                      (pos >= wbs_pkg::POS_W'(need));

    // window entry k holds pattern byte need-1-k when need-len <= k < need
    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cmp
        logic [NEED_W-1:0] kk;
        logic [NEED_W-1:0] j;
        logic [wbs_pkg::PAT_IDX_W-1:0] pj;
        logic              in_use;

        assign kk     = NEED_W'(k);
        assign j      = need - NEED_W'(1) - kk;
        assign pj     = j[wbs_pkg::PAT_IDX_W-1:0];
        assign in_use = (kk < need) && (kk >= first_k);
        assign ok[k]  = !in_use || !cfg.care_mask[pj] || (window[k] == pat[pj*8 +: 8]);
    end

    assign top0 = need - NEED_W'(1) - NEED_W'(cfg.displacement_offset);
    assign top1 = top0 - NEED_W'(1);
    assign top2 = top0 - NEED_W'(2);
    assign top3 = top0 - NEED_W'(3);

    always_comb
    begin
        match.hit   = in_range && (&ok);
        match.start = pos - wbs_pkg::POS_W'(need);
        // little-endian: the oldest of the four bytes is the low byte
        match.disp  = {window[top3[WI_W-1:0]], window[top2[WI_W-1:0]],
                       window[top1[WI_W-1:0]], window[top0[WI_W-1:0]]};
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wbs_scan.sv =====
// Scan stage: byte window, position and hit counters, and the hit record
// register handed to the resolve stage. Depends on wbs_pkg, wbs_match.
`default_nettype none

module wbs_scan #(
    parameter int PATTERN_MAX  = wbs_pkg::PATTERN_MAX_DEF,
    parameter int WINDOW_DEPTH = wbs_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire wbs_pkg::cfg_t     cfg,
    input  wire logic              take,
    input  wire wbs_pkg::in_item_t item,
    output logic                   ready,
    output logic                   rec_valid,
    input  wire logic              rec_ready,
    output wbs_pkg::hit_rec_t      rec
);

    logic [7:0]                   window_reg [WINDOW_DEPTH];
    logic [7:0]                   win_shift  [WINDOW_DEPTH];
    logic [wbs_pkg::POS_W-1:0]    pos_reg;
    logic [wbs_pkg::POS_W-1:0]    pos_next;
    logic [wbs_pkg::POS_W-1:0]    pos_inc;
    logic [wbs_pkg::SKIP_W-1:0]   hits_reg;
    logic [wbs_pkg::SKIP_W-1:0]   hits_next;
    logic                         finished_reg;
    logic                         finished_next;
    logic                         rec_valid_reg;
    logic                         rec_valid_next;
    wbs_pkg::hit_rec_t            rec_reg;
    wbs_pkg::match_t              mt;
    logic                         pos_sat;
    logic                         hit;
    logic                         report_found;
    logic                         report_none;
    logic                         report;

    assign win_shift[0] = item.data_byte;
    for (genvar k = 1; k < WINDOW_DEPTH; k++)
    begin : g_shift
        assign win_shift[k] = window_reg[k-1];
    end

    assign pos_sat = (pos_reg == '1);
    assign pos_inc = pos_reg + wbs_pkg::POS_W'(1);

    wbs_match #(
        .PATTERN_MAX  (PATTERN_MAX),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_match (
        .window (win_shift),
        .pos    (pos_inc),
        .cfg    (cfg),
        .match  (mt)
    );

    assign hit          = !finished_reg && !pos_sat && mt.hit;
    assign report_found = hit && (hits_reg == cfg.matches_to_skip);
    assign report_none  = !finished_reg && item.last_byte && !report_found;
    assign report       = report_found || report_none;

    assign ready = !rec_valid_reg || rec_ready;

    always_comb
    begin
        pos_next       = pos_reg;
        hits_next      = hits_reg;
        finished_next  = finished_reg;
        rec_valid_next = rec_valid_reg && !rec_ready;
        if (take)
        begin
            if (!finished_reg && !pos_sat)
            begin
                pos_next = pos_inc;
            end
            if (hit && !report_found)
            begin
                hits_next = hits_reg + wbs_pkg::SKIP_W'(1);
            end
            if (item.last_byte)
            begin
                pos_next      = '0;
                hits_next     = '0;
                finished_next = 1'b0;
            end
            else if (report_found)
            begin
                finished_next = 1'b1;
            end
            if (report)
            begin
                rec_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            hits_reg      <= '0;
            finished_reg  <= 1'b0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            hits_reg      <= hits_next;
            finished_reg  <= finished_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    // window shifts only while the region is still being scanned
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW_DEPTH; k++)
            begin
                window_reg[k] <= 8'h00;
            end
        end
        else if (take && !finished_reg)
        begin
            window_reg <= win_shift;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && report)
        begin
            rec_reg.found      <= report_found;
            rec_reg.hit_offset <= mt.start;
            rec_reg.disp       <= mt.disp;
            rec_reg.rel        <= cfg.relative_mode;
            rec_reg.disp_skip  <= wbs_pkg::DISP_SKIP_W'(cfg.displacement_offset) +
                                  wbs_pkg::DISP_SKIP_W'(wbs_pkg::DISP_BYTES);
        end
    end

    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

`ifndef SYNTHESIS
    a_region_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.last_byte |=> pos_reg == '0 && hits_reg == '0 && !finished_reg)
        else $error("scan state not cleared after last byte");

    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg && !rec_ready |=> rec_valid_reg && $stable(rec_reg))
        else $error("hit record lost while stalled");

    a_finished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        take && finished_reg && !item.last_byte |=> !rec_valid_reg || $stable(rec_reg))
        else $error("item after a reported hit produced a result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/wbs_resolve.sv =====
// Resolve stage: forms the final address from the hit record and holds the
// result item until it is taken. Depends on wbs_pkg.
`default_nettype none

module wbs_resolve (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [wbs_pkg::ADDR_W-1:0] base_address,
    input  wire logic                       rec_valid,
    output logic                            rec_ready,
    input  wire wbs_pkg::hit_rec_t          rec,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output wbs_pkg::out_item_t              out_item
);

    logic                         out_valid_reg;
    logic                         out_valid_next;
    wbs_pkg::out_item_t           out_item_reg;
    logic [wbs_pkg::ADDR_W-1:0]   rel_term;
    logic [wbs_pkg::ADDR_W-1:0]   addr;
    logic                         load;

    assign rec_ready = !out_valid_reg || out_ready;
    assign load      = rec_valid && rec_ready;

    // 64-bit wrap is the natural overflow of the sum
    assign rel_term = rec.rel ?
        ({{(wbs_pkg::ADDR_W-wbs_pkg::DISP_W){rec.disp[wbs_pkg::DISP_W-1]}}, rec.disp} +
         wbs_pkg::ADDR_W'(rec.disp_skip)) : '0;
    assign addr = base_address + wbs_pkg::ADDR_W'(rec.hit_offset) + rel_term;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg.found          <= rec.found;
            out_item_reg.result_address <= rec.found ? addr : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.found |-> out_item_reg.result_address == '0)
        else $error("not-found result carries an address");
`endif

endmodule

`default_nettype wire
